@@ sv/ble_pkg.sv @@
`default_nettype none

package ble_pkg;

  // Field widths
  localparam int NOW_W     = 32;
  localparam int GAUGE_W   = 8;
  localparam int MV_W      = 16;
  localparam int PCT_W     = 7;
  localparam int IVL_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_PMU_PRESENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_IVL  = 1'b1;

  localparam logic [IVL_W-1:0] IVL_RESET = 16'd2000;

  // Gauge readings from 0 to this value are trusted
  localparam logic signed [GAUGE_W-1:0] GAUGE_MAX = 8'sd100;

  // LiPo discharge curve: end points and eight linear segments
  localparam int SEGS = 8;
  localparam logic [12:0] CURVE_TOP_MV = 13'd4200;
  localparam logic [12:0] CURVE_BOT_MV = 13'd3300;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  localparam logic [12:0] SEG_HI_MV [SEGS] =
    '{13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3700, 13'd3600, 13'd3500};
  localparam logic [12:0] SEG_LO_MV [SEGS] =
    '{13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3700, 13'd3600, 13'd3500, 13'd3300};
  localparam logic [PCT_W-1:0] SEG_LO_PCT [SEGS] =
    '{7'd90, 7'd80, 7'd65, 7'd45, 7'd25, 7'd12, 7'd5, 7'd0};
  // Segment slope (percent per segment) times 5243, so that
  // (offset * scale) >> 19 == offset * slope / 100 for products below 4096
  localparam logic [16:0] SEG_SCALE [SEGS] =
    '{17'd52430, 17'd52430, 17'd78645, 17'd104860,
      17'd104860, 17'd68159, 17'd36701, 17'd26215};
  // 200 mV wide segment: one more bit of shift divides by 200
  localparam logic SEG_HALVE [SEGS] =
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

  localparam int DIV100_SHIFT = 19;

endpackage

`default_nettype wire

@@ sv/ble_query_if.sv @@
`default_nettype none

interface ble_query_if import ble_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [NOW_W-1:0]          now_ms;
  logic signed [GAUGE_W-1:0] gauge_percent;
  logic [MV_W-1:0]           batt_mv;

  modport source (output valid, now_ms, gauge_percent, batt_mv, input ready);
  modport sink   (input valid, now_ms, gauge_percent, batt_mv, output ready);
endinterface

`default_nettype wire

@@ sv/ble_result_if.sv @@
`default_nettype none

interface ble_result_if import ble_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] percent;
  logic             from_gauge;

  modport source (output valid, percent, from_gauge, input ready);
  modport sink   (input valid, percent, from_gauge, output ready);
endinterface

`default_nettype wire

@@ sv/ble_cfg_if.sv @@
`default_nettype none

interface ble_cfg_if import ble_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/battery_level_estimator_core.sv @@
`default_nettype none

// Battery level estimator. Each query request (timestamp, fuel-gauge reading,
// battery voltage) yields one charge estimate in percent. With pmu_present
// clear the answer is 0; a gauge reading of 0..100 is passed through with
// from_gauge set; otherwise a smoothed voltage (first sample loaded, then a
// quarter of the difference added, no more often than update_interval_ms)
// is mapped through a nine-point LiPo curve with linear interpolation,
// clamped to 100 at 4200 mV and above and 0 at 3300 mV and below. The block
// takes one request per clock while results are being read: the request
// sits in the input register and all the work (source select, smoothing,
// segment pick, interpolation and clamp) is done in one pass into the
// result register, offered from the edge loading it. The smoothed voltage is
// written on that same edge, so a request right behind sees the new value.
// The input register holds its request only while the result register is
// full and not being read, so a stalled result still lets one more request
// in. Configuration writes are always ready and take effect on the next
// cycle; write them only while the block is empty.
module battery_level_estimator_core import ble_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  ble_query_if.sink    query,
  ble_cfg_if.sink      cfg,
  ble_result_if.source result
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic             pmu_present;
  logic [IVL_W-1:0] update_interval_ms;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pmu_present        <= 1'b0;
      update_interval_ms <= IVL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PMU_PRESENT: pmu_present        <= cfg.data[0];
        CFG_UPDATE_IVL:  update_interval_ms <= cfg.data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: a register loads when it is empty or its successor
  // loads too.
  // ---------------------------------------------------------------------
  logic v0, v1;
  logic en0, en1;

  assign en1 = !v1 || result.ready;
  assign en0 = !v0 || en1;

  assign query.ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (en0) v0 <= query.valid;
      if (en1) v1 <= v0;
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic [NOW_W-1:0]          now_q;
  logic signed [GAUGE_W-1:0] gauge_q;
  logic [MV_W-1:0]           batt_q;

  always_ff @(posedge clk) begin
    if (en0) begin
      now_q   <= query.now_ms;
      gauge_q <= query.gauge_percent;
      batt_q  <= query.batt_mv;
    end
  end

  // ---------------------------------------------------------------------
  // Source select and voltage smoothing. The smoothed voltage is updated
  // as the request moves into the result register.
  // ---------------------------------------------------------------------
  logic [MV_W-1:0]  smoothed_mv;
  logic [NOW_W-1:0] last_update_ms;

  logic [NOW_W-1:0] elapsed;
  logic             gauge_ok;
  logic             do_update;
  logic [MV_W-1:0]  sm_step;
  logic [MV_W-1:0]  smoothed_mv_next;
  logic [MV_W-1:0]  cur_mv;
  logic             state_wr;

  assign elapsed  = now_q - last_update_ms;
  assign gauge_ok = !gauge_q[GAUGE_W-1] && (gauge_q <= GAUGE_MAX);
  // no sample yet, or the interval has strictly passed (wrapping time)
  assign do_update = (smoothed_mv == '0) ||
                     (elapsed > {{(NOW_W-IVL_W){1'b0}}, update_interval_ms});

  // cur + trunc((sample - cur) / 4), rounded toward zero both ways
  always_comb begin
    if (batt_q >= smoothed_mv) begin
      sm_step = smoothed_mv + ((batt_q - smoothed_mv) >> 2);
    end else begin
      sm_step = smoothed_mv - ((smoothed_mv - batt_q) >> 2);
    end
  end

  assign smoothed_mv_next = (smoothed_mv == '0) ? batt_q : sm_step;
  // voltage the curve sees: the refreshed value when a refresh happens
  assign cur_mv = do_update ? smoothed_mv_next : smoothed_mv;

  // ---------------------------------------------------------------------
  // Curve: pick the segment, then offset times a per-segment constant
  // that folds the slope and the division by 100 into one multiply
  // ---------------------------------------------------------------------
  logic [2:0]       seg;
  logic [7:0]       seg_off;
  logic [24:0]      quot_full;
  logic [PCT_W-1:0] quot;
  logic [PCT_W-1:0] curve_pct;

  // segments are disjoint, at most one matches
  always_comb begin
    seg = '0;
    for (int k = 0; k < SEGS; k++) begin
      if (cur_mv <= MV_W'(SEG_HI_MV[k]) && cur_mv > MV_W'(SEG_LO_MV[k])) begin
        seg = 3'(k);
      end
    end
  end

  // offset into a segment is at most 200 mV
  assign seg_off   = 8'(cur_mv - MV_W'(SEG_LO_MV[seg]));
  assign quot_full = 25'(seg_off) * 25'(SEG_SCALE[seg]);
  assign quot      = SEG_HALVE[seg] ? PCT_W'(quot_full >> (DIV100_SHIFT + 1)) :
                                      PCT_W'(quot_full >> DIV100_SHIFT);

  always_comb begin
    priority if (cur_mv >= MV_W'(CURVE_TOP_MV)) begin
      curve_pct = PCT_FULL;
    end else if (cur_mv <= MV_W'(CURVE_BOT_MV)) begin
      curve_pct = PCT_EMPTY;
    end else begin
      curve_pct = SEG_LO_PCT[seg] + quot;
    end
  end

  // ---------------------------------------------------------------------
  // Result select, state update and result register
  // ---------------------------------------------------------------------
  logic [PCT_W-1:0] pct_next;
  logic             fg_next;
  logic [PCT_W-1:0] percent_q;
  logic             from_gauge_q;

  always_comb begin
    pct_next = PCT_EMPTY;
    fg_next  = 1'b0;
    state_wr = 1'b0;
    priority if (!pmu_present) begin
      pct_next = PCT_EMPTY;
    end else if (gauge_ok) begin
      pct_next = gauge_q[PCT_W-1:0];
      fg_next  = 1'b1;
    end else begin
      pct_next = curve_pct;
      state_wr = do_update;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_mv    <= '0;
      last_update_ms <= '0;
    end else if (en1 && v0 && state_wr) begin
      smoothed_mv    <= smoothed_mv_next;
      last_update_ms <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      percent_q    <= pct_next;
      from_gauge_q <= fg_next;
    end
  end

  assign result.valid      = v1;
  assign result.percent    = percent_q;
  assign result.from_gauge = from_gauge_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Testbench for battery_level_estimator_core.
// A directed plan walks the clamps, the pass-through and the smoothing
// corner cases, then nine random blocks follow under three idling mixes.
// Estimates are checked against typed plan values or a behavioural predictor.
module tb;
  import ble_pkg::*;

  localparam int PIPE_DEPTH  = 1;      // padding for the drain waits
  localparam int BLOCKS      = 9;
  localparam int BLOCK_ITEMS = 150;
  localparam int DRAIN_LIMIT = 20000;
  localparam int FULL_MV     = 4200;   // curve clamps to 100 at or above
  localparam int EMPTY_MV    = 3300;   // and to 0 at or below

  typedef struct packed {
    logic [NOW_W-1:0]   now;
    logic [GAUGE_W-1:0] gauge;
    logic [MV_W-1:0]    mv;
  } query_t;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic             from_gauge;
  } estimate_t;

  typedef enum logic {ROW_QUERY, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    query_t               q;
    logic                 typed;  // expectation written into the plan
    estimate_t            est;
  } row_t;

  logic clk;
  logic rst;

  ble_query_if  q_if ();
  ble_cfg_if    c_if ();
  ble_result_if r_if ();

  battery_level_estimator_core dut (
    .clk   (clk),
    .rst   (rst),
    .query (q_if),
    .cfg   (c_if),
    .result(r_if)
  );

  // predictor state: registers and the smoothing filter
  logic             pmu_on;
  logic [IVL_W-1:0] ivl_ms;
  logic [MV_W-1:0]  filt_mv;
  logic [NOW_W-1:0] filt_stamp_ms;

  estimate_t pending_estimates [$];
  row_t      plan [$];

  int fails;
  int n_queries, n_directed, n_checked, n_from_gauge, n_cfg_writes;
  int snd_idle, rcv_idle;  // percent of cycles each side idles

  // random stimulus state
  logic [NOW_W-1:0] clock_ms;
  int               target_mv;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TIMEOUT after 5 ms of simulated time");
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fails++;
  endtask

  // Voltage to percent along the nine-point LiPo curve, truncating division.
  function automatic logic [PCT_W-1:0] curve_percent(input logic [MV_W-1:0] mv);
    int unsigned hi, lo, ph, pl;
    if (mv >= FULL_MV) return 7'd100;
    if (mv <= EMPTY_MV) return 7'd0;
    if (mv > 4100) begin
      hi = 4200; lo = 4100; ph = 100; pl = 90;
    end else if (mv > 4000) begin
      hi = 4100; lo = 4000; ph = 90;  pl = 80;
    end else if (mv > 3900) begin
      hi = 4000; lo = 3900; ph = 80;  pl = 65;
    end else if (mv > 3800) begin
      hi = 3900; lo = 3800; ph = 65;  pl = 45;
    end else if (mv > 3700) begin
      hi = 3800; lo = 3700; ph = 45;  pl = 25;
    end else if (mv > 3600) begin
      hi = 3700; lo = 3600; ph = 25;  pl = 12;
    end else if (mv > 3500) begin
      hi = 3600; lo = 3500; ph = 12;  pl = 5;
    end else begin
      hi = 3500; lo = 3300; ph = 5;   pl = 0;
    end
    return PCT_W'(pl + (mv - lo) * (ph - pl) / (hi - lo));
  endfunction

  // Quarter-step towards the sample, truncated towards zero in both directions.
  function automatic logic [MV_W-1:0] ease_toward(input logic [MV_W-1:0] cur,
                                                  input logic [MV_W-1:0] sample);
    if (sample >= cur) return cur + ((sample - cur) >> 2);
    return cur - ((cur - sample) >> 2);
  endfunction

  // Expected estimate for one accepted query; advances the filter state.
  function automatic estimate_t estimate_charge(input query_t qi);
    int               g;
    logic [NOW_W-1:0] gap;
    estimate_t        e;
    g = $signed(qi.gauge);
    e.pct = '0;
    e.from_gauge = 1'b0;
    if (!pmu_on) return e;
    if (g >= 0 && g <= 100) begin
      e.pct = PCT_W'(g);
      e.from_gauge = 1'b1;
      return e;
    end
    gap = qi.now - filt_stamp_ms;  // wraps modulo 2^32
    if (filt_mv == '0 || gap > {16'd0, ivl_ms}) begin
      filt_stamp_ms = qi.now;
      filt_mv = (filt_mv == '0) ? qi.mv : ease_toward(filt_mv, qi.mv);
    end
    e.pct = curve_percent(filt_mv);
    return e;
  endfunction

  function automatic row_t qrow(input logic [NOW_W-1:0] now, input logic [GAUGE_W-1:0] g,
                                input logic [MV_W-1:0] mv, input logic typed,
                                input logic [PCT_W-1:0] pct, input logic fg);
    row_t r;
    r = '0;
    r.kind = ROW_QUERY;
    r.q = '{now, g, mv};
    r.typed = typed;
    r.est = '{pct, fg};
    return r;
  endfunction

  function automatic row_t crow(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // Present one query request, idling first at random; returns on the
  // accepting edge with valid still high so back-to-back requests stream.
  // Handshake signals are sampled at the falling edge, where they are settled.
  task automatic put_query(input query_t qi, input logic typed, input estimate_t typed_est);
    logic      acc;
    estimate_t e;
    while ($urandom_range(0, 99) < snd_idle) begin
      q_if.valid <= 1'b0;
      @(posedge clk);
    end
    q_if.valid         <= 1'b1;
    q_if.now_ms        <= qi.now;
    q_if.gauge_percent <= qi.gauge;
    q_if.batt_mv       <= qi.mv;
    do begin
      @(negedge clk);
      acc = q_if.ready;
      @(posedge clk);
    end while (!acc);
    e = estimate_charge(qi);
    pending_estimates.push_back(typed ? typed_est : e);
    n_queries++;
  endtask

  // Register write: only with the pipeline empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    logic acc;
    q_if.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    c_if.valid <= 1'b1;
    c_if.index <= idx;
    c_if.data  <= data;
    do begin
      @(negedge clk);
      acc = c_if.ready;
      @(posedge clk);
    end while (!acc);
    c_if.valid <= 1'b0;
    if (idx == CFG_PMU_PRESENT) pmu_on = data[0];
    else ivl_ms = data;
    n_cfg_writes++;
  endtask

  // Random query: time mostly steps around the update interval so that the
  // filter is refreshed about half the time; voltage follows a slowly moving
  // target so the filtered value settles across every curve segment.
  function automatic query_t draw_query();
    query_t qi;
    int     r, m, v;
    r = $urandom_range(0, 99);
    if (r < 20)      clock_ms += $urandom_range(0, 3);
    else if (r < 40) clock_ms += ivl_ms;
    else if (r < 60) clock_ms += ivl_ms + 1;
    else if (r < 85) clock_ms += $urandom_range(ivl_ms + 1, ivl_ms + 200);
    else if (r < 97) clock_ms += $urandom_range(0, 2 * ivl_ms + 2);
    else             clock_ms = $urandom();  // jump, often backwards
    qi.now = clock_ms;

    if ($urandom_range(0, 15) == 0) begin
      r = $urandom_range(0, 99);
      if (r < 90)      target_mv = $urandom_range(3200, 4300);
      else if (r < 95) target_mv = $urandom_range(0, EMPTY_MV - 1);
      else             target_mv = $urandom_range(FULL_MV, 65535);
    end
    if ($urandom_range(0, 99) < 3) begin
      qi.mv = MV_W'($urandom());
    end else begin
      m = target_mv + $urandom_range(0, 80) - 40;
      if (m < 0) m = 0;
      if (m > 65535) m = 65535;
      qi.mv = MV_W'(m);
    end

    r = $urandom_range(0, 99);
    if (r < 30) begin
      qi.gauge = GAUGE_W'($urandom_range(0, 100));
    end else if (r < 35) begin
      case ($urandom_range(0, 5))
        0: qi.gauge = 8'h00;
        1: qi.gauge = 8'd100;
        2: qi.gauge = 8'd101;
        3: qi.gauge = 8'hFF;
        4: qi.gauge = 8'h7F;
        default: qi.gauge = 8'h80;
      endcase
    end else begin
      // out of the trusted range: -128..-1 or 101..127
      v = $urandom_range(0, 154);
      qi.gauge = (v < 128) ? GAUGE_W'(-1 - v) : GAUGE_W'(101 + v - 128);
    end
    return qi;
  endfunction

  // Result side: random back-pressure, check on the falling edge before the
  // accepting rising edge.
  initial begin
    r_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      r_if.ready <= !rst && ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(negedge clk) begin
    estimate_t e;
    if (!rst && r_if.valid && r_if.ready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch($sformatf("unexpected estimate pct=%0d from_gauge=%0d",
                                  r_if.percent, r_if.from_gauge));
      end else begin
        e = pending_estimates.pop_front();
        n_checked++;
        if (r_if.from_gauge) n_from_gauge++;
        if (r_if.percent !== e.pct)
          report_mismatch($sformatf("estimate #%0d percent %0d, want %0d",
                                    n_checked, r_if.percent, e.pct));
        if (r_if.from_gauge !== e.from_gauge)
          report_mismatch($sformatf("estimate #%0d from_gauge %0d, want %0d",
                                    n_checked, r_if.from_gauge, e.from_gauge));
      end
    end
  end

  initial begin
    estimate_t none;
    int        waited;
    query_t    qi;
    logic [CFG_W-1:0] d;
    int        r;

    none = '0;
    fails = 0;
    n_queries = 0; n_directed = 0; n_checked = 0; n_from_gauge = 0; n_cfg_writes = 0;
    snd_idle = 21;
    rcv_idle = 78;
    pmu_on = 1'b0;
    ivl_ms = IVL_RESET;
    filt_mv = '0;
    filt_stamp_ms = '0;
    target_mv = 3900;

    rst                <= 1'b1;
    q_if.valid         <= 1'b0;
    q_if.now_ms        <= '0;
    q_if.gauge_percent <= '0;
    q_if.batt_mv       <= '0;
    c_if.valid         <= 1'b0;
    c_if.index         <= CFG_PMU_PRESENT;
    c_if.data          <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // ---- directed plan ----
    // after reset the power unit is absent: always 0, even at the extremes
    plan.push_back(qrow(32'd0, 8'd50, 16'd4000, 1, 7'd0, 0));
    plan.push_back(qrow(32'hFFFF_FFFF, 8'h80, 16'hFFFF, 1, 7'd0, 0));
    // only bit 0 of the write data counts
    plan.push_back(crow(CFG_PMU_PRESENT, 16'hFFFE));
    plan.push_back(qrow(32'h1234_5678, 8'd100, 16'd3700, 1, 7'd0, 0));
    plan.push_back(crow(CFG_PMU_PRESENT, 16'h0001));
    // trusted gauge range passes through at both ends
    plan.push_back(qrow(32'd10, 8'd0, 16'd4000, 1, 7'd0, 1));
    plan.push_back(qrow(32'd11, 8'd100, 16'd0, 1, 7'd100, 1));
    // zero sample on the first refresh leaves the filter empty
    plan.push_back(qrow(32'd12, 8'h7F, 16'd0, 1, 7'd0, 0));
    // still empty, so this loads regardless of time: bottom clamp
    plan.push_back(qrow(32'd13, 8'd101, 16'd3300, 1, 7'd0, 0));
    // within the interval, then exactly at it, then one past it
    plan.push_back(qrow(32'd14, 8'hFF, 16'hFFFF, 0, 7'd0, 0));
    plan.push_back(qrow(32'd2013, 8'h80, 16'hFFFF, 0, 7'd0, 0));
    plan.push_back(qrow(32'd2014, 8'hFF, 16'hFFFF, 0, 7'd0, 0));
    // zero interval: same stamp holds, next millisecond refreshes
    plan.push_back(crow(CFG_UPDATE_IVL, 16'd0));
    plan.push_back(qrow(32'd2014, 8'h7F, 16'd3000, 0, 7'd0, 0));
    plan.push_back(qrow(32'd2015, 8'h7F, 16'd3000, 0, 7'd0, 0));
    plan.push_back(qrow(32'd2016, 8'h80, 16'd4150, 0, 7'd0, 0));
    // widest interval, with the timestamp wrapping through zero
    plan.push_back(crow(CFG_UPDATE_IVL, 16'hFFFF));
    plan.push_back(qrow(32'hFFFF_0000, 8'hFE, 16'd3900, 0, 7'd0, 0));
    plan.push_back(qrow(32'h0000_FFFF, 8'hFD, 16'd3900, 0, 7'd0, 0));
    plan.push_back(qrow(32'h0001_0000, 8'hFC, 16'd3900, 0, 7'd0, 0));
    plan.push_back(qrow(32'h0001_0000, 8'd55, 16'd3900, 1, 7'd55, 1));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        put_query(plan[i].q, plan[i].typed, plan[i].est);
        n_directed++;
      end
    end

    // ---- random blocks ----
    for (int blk = 0; blk < BLOCKS; blk++) begin
      // idling mix: sender light / receiver heavy, then swapped, then none
      if (blk < 3) begin
        snd_idle = 21; rcv_idle = 78;
      end else if (blk < 6) begin
        snd_idle = 78; rcv_idle = 21;
      end else begin
        snd_idle = 0;  rcv_idle = 0;
      end

      case (blk)
        0: d = 16'd0;
        1: d = 16'hFFFF;
        2: d = CFG_W'($urandom_range(1, 50));
        3: d = CFG_W'($urandom());
        default: begin
          r = $urandom_range(0, 99);
          if (r < 40)      d = CFG_W'($urandom_range(0, 100));
          else if (r < 70) d = CFG_W'($urandom_range(0, 5000));
          else             d = CFG_W'($urandom());
        end
      endcase
      write_reg(CFG_UPDATE_IVL, d);

      // one block runs with the power unit absent; upper data bits are noise
      d = CFG_W'($urandom());
      d[0] = (blk != 4);
      write_reg(CFG_PMU_PRESENT, d);

      // some blocks start just short of the timestamp wrap
      clock_ms = (blk % 2) ? NOW_W'(-$urandom_range(0, 200000)) : NOW_W'($urandom());

      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        qi = draw_query();
        put_query(qi, 1'b0, none);
      end
    end

    q_if.valid <= 1'b0;
    waited = 0;
    while (pending_estimates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_estimates.size() != 0)
      report_mismatch($sformatf("%0d estimates never arrived", pending_estimates.size()));
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("Ran %0d queries (%0d directed) and %0d register writes over three idling mixes.",
             n_queries, n_directed, n_cfg_writes);
    $display("Checked %0d estimates, %0d taken from the gauge; %0d mismatches.",
             n_checked, n_from_gauge, fails);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
